### rtl/ilp_pkg.sv
// Shared types and constants of the IPv4 line parser.
// Used by the step logic, the top level and the test bench; no dependencies.
package ilp_pkg;

  // character codes
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // counts and limits
  localparam logic [2:0] FIELDS_NEEDED = 3'd4;
  localparam logic [2:0] TOKENS_NEEDED = 3'd3;
  localparam logic [2:0] COUNT_MAX     = 3'd7;
  localparam logic [8:0] VALUE_CAP     = 9'd256;
  localparam logic [8:0] FIELD_MAX     = 9'd255;

  // parser state carried from byte to byte
  typedef struct packed {
    logic [2:0]  token_count;
    logic        in_token;
    logic [2:0]  field_count;
    logic [8:0]  field_value;
    logic        field_has_chars;
    logic        field_bad;
    logic [31:0] address_acc;
    logic        line_bad;
    logic        all_lines_ok;
  } ilp_state_t;

  // one result item
  typedef struct packed {
    logic [31:0] address;
    logic        line_ok;
    logic        stream_ok;
    logic        last;
  } ilp_result_t;

endpackage

### rtl/ilp_if.sv
// Valid/ready channel interfaces for text bytes in and line results out.
// Depends on nothing outside this file.
interface ilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_stream;

  modport source (output valid, output char_byte, output end_of_stream, input ready);
  modport sink   (input valid, input char_byte, input end_of_stream, output ready);
endinterface

interface ilp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        line_ok;
  logic        stream_ok;
  logic        last;

  modport source (output valid, output address, output line_ok, output stream_ok,
                  output last, input ready);
  modport sink   (input valid, input address, input line_ok, input stream_ok,
                  input last, output ready);
endinterface

### rtl/ilp_step.sv
// Combinational next-state and result logic for one text byte.
// Depends on ilp_pkg for the state and result types and character codes.
module ilp_step
  import ilp_pkg::*;
(
  input  ilp_state_t  cur,
  input  logic [7:0]  char_byte,
  input  logic        end_of_stream,
  output ilp_state_t  nxt,
  output logic        has_result,
  output ilp_result_t result
);

  // close the current address field and shift it into the address, or mark the line bad
  function automatic ilp_state_t close_field(input ilp_state_t s);
    ilp_state_t r;
    r = s;
    if (s.field_count >= FIELDS_NEEDED || !s.field_has_chars || s.field_bad ||
        s.field_value > FIELD_MAX) begin
      r.line_bad = 1'b1;
    end else begin
      r.address_acc = {s.address_acc[23:0], s.field_value[7:0]};
    end
    if (s.field_count < COUNT_MAX) begin
      r.field_count = s.field_count + 3'd1;
    end
    r.field_value     = '0;
    r.field_has_chars = 1'b0;
    r.field_bad       = 1'b0;
    return r;
  endfunction

  // whitespace or line end closes a token; the first token must have four fields
  function automatic ilp_state_t end_token(input ilp_state_t s);
    ilp_state_t r;
    r = s;
    if (s.in_token && s.token_count == 3'd1) begin
      if (s.field_has_chars) begin
        r = close_field(s);
      end
      if (r.field_count != FIELDS_NEEDED) begin
        r.line_bad = 1'b1;
      end
    end
    r.in_token = 1'b0;
    return r;
  endfunction

  // one byte of the address token
  function automatic ilp_state_t feed_address(input ilp_state_t s, input logic [7:0] c);
    ilp_state_t  r;
    logic [11:0] v;
    r = s;
    v = 12'(s.field_value) * 12'd10 + 12'(c[3:0]);
    if (c == CHAR_DOT) begin
      r = close_field(s);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.field_value     = (v > 12'(VALUE_CAP)) ? VALUE_CAP : v[8:0];
      r.field_has_chars = 1'b1;
    end else begin
      r.field_bad       = 1'b1;
      r.field_has_chars = 1'b1;
    end
    return r;
  endfunction

  logic       is_nl;
  logic       is_space;
  ilp_state_t after_byte;
  ilp_state_t closed;
  logic       ok;

  assign is_nl    = (char_byte == CHAR_NL);
  assign is_space = (char_byte == CHAR_SPACE) ||
                    (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);

  // byte itself: token boundary or token byte
  always_comb begin
    after_byte = cur;
    if (!is_nl) begin
      if (is_space) begin
        after_byte = end_token(cur);
      end else begin
        if (!cur.in_token) begin
          after_byte.in_token = 1'b1;
          if (cur.token_count < COUNT_MAX) begin
            after_byte.token_count = cur.token_count + 3'd1;
          end
        end
        if (after_byte.token_count == 3'd1) begin
          after_byte = feed_address(after_byte, char_byte);
        end
      end
    end
  end

  // line end: judge the line and clear per-line state
  always_comb begin
    has_result = is_nl || end_of_stream;
    closed     = end_token(after_byte);
    ok         = !closed.line_bad && closed.token_count == TOKENS_NEEDED;

    result.address   = ok ? closed.address_acc : '0;
    result.line_ok   = ok;
    result.stream_ok = closed.all_lines_ok && ok;
    result.last      = end_of_stream;

    if (has_result) begin
      nxt              = '0;
      nxt.all_lines_ok = end_of_stream ? 1'b1 : (closed.all_lines_ok && ok);
    end else begin
      nxt = after_byte;
    end
  end

endmodule

### rtl/ipv4_line_parser_unit.sv
// Top level of the IPv4 line parser: input register, step logic, result register.
// Depends on ilp_pkg, the channel interfaces in ilp_if.sv and ilp_step.
//
// Takes one text byte per clock and gives one result item per line end (newline,
// or the byte flagged end_of_stream): the dotted IPv4 address of the line's first
// token, a line_ok flag (three tokens and a valid address) and a sticky stream_ok
// flag; last marks the stream's final line, after which the parser starts a new
// stream. A byte is held in the input register and its result, if any, is loaded
// into the result register when that byte is processed. Sustained rate is one byte
// per clock; the only stall comes from a result the sink has not yet taken when the
// next line ends.
module ipv4_line_parser_unit
  import ilp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ilp_in_if.sink           byte_in,
  ilp_out_if.source        line_out
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eos;

  // parser state and result register
  ilp_state_t  state;
  ilp_state_t  state_next;
  logic        step_result;
  ilp_result_t step_res;
  logic        out_valid;
  ilp_result_t out_res;

  logic out_free;
  logic process;

  ilp_step u_step (
    .cur           (state),
    .char_byte     (in_char),
    .end_of_stream (in_eos),
    .nxt           (state_next),
    .has_result    (step_result),
    .result        (step_res)
  );

  // a byte moves on unless its result would hit a full result register
  assign out_free       = !out_valid || line_out.ready;
  assign process        = in_valid && (!step_result || out_free);
  assign byte_in.ready  = !in_valid || process;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_char <= byte_in.char_byte;
      in_eos  <= byte_in.end_of_stream;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{all_lines_ok: 1'b1, default: '0};
    end else if (process) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && step_result) begin
      out_valid <= 1'b1;
    end else if (line_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && step_result) begin
      out_res <= step_res;
    end
  end

  assign line_out.valid     = out_valid;
  assign line_out.address   = out_res.address;
  assign line_out.line_ok   = out_res.line_ok;
  assign line_out.stream_ok = out_res.stream_ok;
  assign line_out.last      = out_res.last;

  // invalid lines report a zero address
  a_bad_line_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.line_ok |-> out_res.address == 32'd0)
    else $error("invalid line with nonzero address");

  // a good stream flag needs a good line
  a_stream_implies_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.stream_ok |-> out_res.line_ok)
    else $error("stream_ok without line_ok");

  // after the final line the parser is back at its reset state
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    process && step_result && in_eos |=>
      state.all_lines_ok && state.token_count == 3'd0 && !state.in_token)
    else $error("state not cleared after final line");

  // the input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> in_valid && out_valid && !line_out.ready)
    else $error("input stalled without a blocked result");

endmodule

### bench/ipv4_line_parser_unit_test.sv
// Self-checking bench for ipv4_line_parser_unit: byte items in, line result items out.
// Depends on ilp_pkg, the channel interfaces in ilp_if.sv and the parser top level.
module ipv4_line_parser_unit_test;
  import ilp_pkg::*;

  // whitespace bytes the package has no name for
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam ilp_result_t NO_LINE = '0;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eos;
    logic        fixed;
    ilp_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ilp_in_if  byte_in();
  ilp_out_if line_out();

  ipv4_line_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .line_out (line_out)
  );

  always #5 clk = ~clk;

  // directed items: valid line, empty line, last line without newline, new stream
  stim_row_t plan [19] = '{
    {"1",        1'b0, 1'b0, NO_LINE},
    {CHAR_DOT,   1'b0, 1'b0, NO_LINE},
    {"2",        1'b0, 1'b0, NO_LINE},
    {CHAR_DOT,   1'b0, 1'b0, NO_LINE},
    {"3",        1'b0, 1'b0, NO_LINE},
    {CHAR_DOT,   1'b0, 1'b0, NO_LINE},
    {"4",        1'b0, 1'b0, NO_LINE},
    {CHAR_TAB,   1'b0, 1'b0, NO_LINE},
    {8'hFF,      1'b0, 1'b0, NO_LINE},
    {CHAR_CR,    1'b0, 1'b0, NO_LINE},
    {8'h00,      1'b0, 1'b0, NO_LINE},
    {CHAR_NL,    1'b0, 1'b1, {32'h01020304, 1'b1, 1'b1, 1'b0}},
    {CHAR_NL,    1'b0, 1'b1, {32'h00000000, 1'b0, 1'b0, 1'b0}},
    {"9",        1'b0, 1'b0, NO_LINE},
    {CHAR_VT,    1'b0, 1'b0, NO_LINE},
    {"a",        1'b0, 1'b0, NO_LINE},
    {CHAR_FF,    1'b0, 1'b0, NO_LINE},
    {"b",        1'b1, 1'b1, {32'h00000000, 1'b0, 1'b0, 1'b1}},
    {CHAR_NL,    1'b1, 1'b1, {32'h00000000, 1'b0, 1'b0, 1'b1}}
  };

  ilp_result_t lines_due[$];
  logic [7:0]  line_buf[$];
  bit          line_eos;

  int src_idle_pct;
  int snk_idle_pct;
  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int lines_good = 0;
  int streams_closed = 0;

  // parser shadow state
  logic [2:0]  tok_cnt;
  logic        in_tok;
  logic [2:0]  fld_cnt;
  logic [8:0]  fld_val;
  logic        fld_seen;
  logic        fld_junk;
  logic [31:0] addr_sr;
  logic        addr_bad;
  logic        stream_good;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic void clear_line();
    tok_cnt = '0;
    in_tok = 1'b0;
    fld_cnt = '0;
    fld_val = '0;
    fld_seen = 1'b0;
    fld_junk = 1'b0;
    addr_sr = '0;
    addr_bad = 1'b0;
  endfunction

  function automatic void reset_parser();
    clear_line();
    stream_good = 1'b1;
  endfunction

  // shift a finished field into the address, or mark the address bad
  function automatic void close_field();
    if (fld_cnt >= FIELDS_NEEDED || !fld_seen || fld_junk || fld_val > FIELD_MAX) begin
      addr_bad = 1'b1;
    end else begin
      addr_sr = {addr_sr[23:0], fld_val[7:0]};
    end
    if (fld_cnt < COUNT_MAX) fld_cnt = fld_cnt + 3'd1;
    fld_val = '0;
    fld_seen = 1'b0;
    fld_junk = 1'b0;
  endfunction

  function automatic void finish_token();
    if (in_tok && tok_cnt == 3'd1) begin
      if (fld_seen) close_field();
      if (fld_cnt != FIELDS_NEEDED) addr_bad = 1'b1;
    end
    in_tok = 1'b0;
  endfunction

  function automatic void take_addr_char(input logic [7:0] c);
    int unsigned v;
    if (c == CHAR_DOT) begin
      close_field();
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = fld_val * 10 + (c - CHAR_ZERO);
      fld_val = (v > VALUE_CAP) ? VALUE_CAP : 9'(v);
      fld_seen = 1'b1;
    end else begin
      fld_junk = 1'b1;
      fld_seen = 1'b1;
    end
  endfunction

  // advance the shadow parser by one byte; returns 1 when a line closes
  function automatic bit parse_byte(input logic [7:0] c, input logic eos,
                                    output ilp_result_t res);
    bit ok;
    res = NO_LINE;
    if (c != CHAR_NL) begin
      if (is_blank(c)) begin
        finish_token();
      end else begin
        if (!in_tok) begin
          in_tok = 1'b1;
          if (tok_cnt < COUNT_MAX) tok_cnt = tok_cnt + 3'd1;
        end
        if (tok_cnt == 3'd1) take_addr_char(c);
      end
    end
    if (c != CHAR_NL && !eos) return 1'b0;
    finish_token();
    ok = !addr_bad && tok_cnt == TOKENS_NEEDED;
    stream_good = stream_good && ok;
    res.address = ok ? addr_sr : 32'd0;
    res.line_ok = ok;
    res.stream_ok = stream_good;
    res.last = eos;
    if (eos) reset_parser();
    else clear_line();
    return 1'b1;
  endfunction

  // append one byte to the line being built
  function automatic void add_byte(input logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  // random line content
  function automatic logic [7:0] pick_space();
    unique case ($urandom_range(7))
      0: return CHAR_TAB;
      1: return CHAR_VT;
      2: return CHAR_FF;
      3: return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_blank(c));
    return c;
  endfunction

  function automatic void put_number(input int unsigned v, input int zeros);
    logic [7:0] digs[$];
    repeat (zeros) add_byte(CHAR_ZERO);
    do begin
      digs.push_front(8'(CHAR_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) add_byte(digs[i]);
  endfunction

  function automatic void put_field(input bit broken);
    int unsigned k;
    int zeros;
    k = $urandom_range(99);
    zeros = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
    if (broken && k < 25) return;
    if (k < (broken ? 80 : 94)) put_number($urandom_range(255), zeros);
    else if (k < (broken ? 92 : 97)) put_number($urandom_range(256, 999), zeros);
    else put_number($urandom_range(1000, 99999999), 0);
    if (broken && $urandom_range(3) == 0) add_byte(pick_text());
  endfunction

  // one line: mostly well formed, some with a broken address, some pure noise
  task automatic make_line();
    int unsigned style;
    int nfields;
    int extra;
    line_buf.delete();
    style = $urandom_range(99);
    if (style >= 88) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) add_byte(pick_space());
      nfields = (style < 70) ? 4 : $urandom_range(6);
      for (int i = 0; i < nfields; i++) begin
        if (i != 0) add_byte(CHAR_DOT);
        put_field(style >= 70);
      end
      if ($urandom_range(6) == 0) begin
        add_byte(CHAR_DOT);
        if (style >= 70 && $urandom_range(1) == 1) add_byte(CHAR_DOT);
      end
      extra = ($urandom_range(9) == 0) ? $urandom_range(4) : 2;
      repeat (extra) begin
        repeat ($urandom_range(1, 3)) add_byte(pick_space());
        repeat ($urandom_range(1, 4)) add_byte(pick_text());
      end
      if ($urandom_range(4) == 0) add_byte(pick_space());
    end
    line_eos = ($urandom_range(11) == 0);
    if (!(line_eos && line_buf.size() != 0 && $urandom_range(1) == 1))
      add_byte(CHAR_NL);
  endtask

  // drive one byte item, predict its result at the accepting edge
  task automatic send_byte(input logic [7:0] ch, input logic eos, input logic fixed,
                           input ilp_result_t typed);
    logic took;
    bit has;
    ilp_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.char_byte <= ch;
    byte_in.end_of_stream <= eos;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = byte_in.ready;
      if (!took) @(posedge clk);
    end
    has = parse_byte(ch, eos, res);
    if (fixed) lines_due = {lines_due, typed};
    else if (has) lines_due = {lines_due, res};
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i])
      send_byte(line_buf[i], line_eos && i == line_buf.size() - 1, 1'b0, NO_LINE);
  endtask

  // hold the sender off until every pending line result has come back or the wait limit is reached
  task automatic drain();
    int waited;
    byte_in.valid <= 1'b0;
    waited = 0;
    while (lines_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (lines_due.size() != 0) begin
      errors++;
      $display("%0t: %0d line results never arrived, next expected address=%h ok=%b",
               $time, lines_due.size(), lines_due[0].address, lines_due[0].line_ok);
      lines_due.delete();
    end
  endtask

  // result side ready, random per phase
  initial begin
    line_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      line_out.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare each accepted result item with the oldest expectation
  always @(negedge clk) begin : check_lines
    ilp_result_t want;
    if (!rst && line_out.valid && line_out.ready) begin
      results_seen++;
      if (line_out.line_ok) lines_good++;
      if (line_out.last) streams_closed++;
      if (lines_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result address=%h line_ok=%b stream_ok=%b last=%b",
                 $time, line_out.address, line_out.line_ok, line_out.stream_ok,
                 line_out.last);
      end else begin
        want = lines_due.pop_front();
        if (want.address !== line_out.address || want.line_ok !== line_out.line_ok ||
            want.stream_ok !== line_out.stream_ok || want.last !== line_out.last) begin
          errors++;
          // flags are line_ok, stream_ok, last
          $display("%0t: expected address=%h flags=%b%b%b, got address=%h flags=%b%b%b",
                   $time, want.address, want.line_ok, want.stream_ok, want.last,
                   line_out.address, line_out.line_ok, line_out.stream_ok, line_out.last);
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("ipv4_line_parser_unit regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    int phase_start;
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.char_byte = 8'h00;
    byte_in.end_of_stream = 1'b0;
    src_idle_pct = 9;
    snk_idle_pct = 51;
    reset_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i].ch, plan[i].eos, plan[i].fixed, plan[i].want);

    // three pacing phases: slow sink, slow source, full rate
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin src_idle_pct = 9;  snk_idle_pct = 51; end
        1: begin src_idle_pct = 51; snk_idle_pct = 9;  end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 120) begin
        make_line();
        send_line();
      end
      drain();
    end

    $display("covered %0d byte items, %0d line results (%0d valid), %0d streams closed",
             bytes_sent, results_seen, lines_good, streams_closed);
    $display("paced with slow sink, slow source and back-to-back traffic");
    if (errors == 0) begin
      $display("ipv4_line_parser_unit regression: pass");
    end else begin
      $display("ipv4_line_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
